// ----- rtl/lpd_pkg.sv -----
// Package with the shared types and constants of the length-prefix deframer.
package lpd_pkg;

  localparam int CONNECTIONS = 16;

  localparam int ID_W   = 4;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 32;
  localparam int CNT_W  = 2;

  localparam int CTX_DEPTH = (CONNECTIONS < (2 ** ID_W)) ? CONNECTIONS : (2 ** ID_W);
  localparam int IDX_W     = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;

  localparam logic OP_DATA       = 1'b0;
  localparam logic OP_DISCONNECT = 1'b1;

  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  localparam logic [CNT_W-1:0] HDR_LAST = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [ID_W-1:0]  connection_id;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic              phase;
    logic [CNT_W-1:0]  header_count;
    logic [LEN_W-1:0]  length_or_remaining;
    logic              body_started;
  } ctx_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   out_connection;
    logic [BYTE_W-1:0] payload_byte;
    logic              first_byte;
    logic              last_byte;
    logic              empty_message;
  } result_t;

  localparam ctx_t CTX_IDLE = '{
    phase: PH_HEADER,
    header_count: '0,
    length_or_remaining: '0,
    body_started: 1'b0
  };

endpackage

// ----- rtl/lpd_if.sv -----
// Valid/ready channel interfaces for the deframer's input and result beats.
interface lpd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [lpd_pkg::ID_W-1:0]    connection_id;
  logic [lpd_pkg::BYTE_W-1:0]  data_byte;

  modport source(output valid, output opcode, output connection_id, output data_byte,
                 input ready);
  modport sink(input valid, input opcode, input connection_id, input data_byte,
               output ready);
endinterface

interface lpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lpd_pkg::ID_W-1:0]    out_connection;
  logic [lpd_pkg::BYTE_W-1:0]  payload_byte;
  logic                        first_byte;
  logic                        last_byte;
  logic                        empty_message;

  modport source(output valid, output out_connection, output payload_byte,
                 output first_byte, output last_byte, output empty_message,
                 input ready);
  modport sink(input valid, input out_connection, input payload_byte,
               input first_byte, input last_byte, input empty_message,
               output ready);
endinterface

// ----- rtl/lpd_ctx_table.sv -----
// Per-connection context table held in flip-flops, cleared at once by reset.
module lpd_ctx_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lpd_pkg::IDX_W-1:0]  rd_idx,
  output lpd_pkg::ctx_t              rd_ctx,
  input  logic                       wr_en,
  input  logic [lpd_pkg::IDX_W-1:0]  wr_idx,
  input  lpd_pkg::ctx_t              wr_ctx
);

  lpd_pkg::ctx_t ctx_r [lpd_pkg::CTX_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpd_pkg::CTX_DEPTH; i++) begin
        ctx_r[i] <= lpd_pkg::CTX_IDLE;
      end
    end else if (wr_en) begin
      ctx_r[wr_idx] <= wr_ctx;
    end
  end

  assign rd_ctx = ctx_r[rd_idx];

endmodule

// ----- rtl/lpd_frame_logic.sv -----
// Header assembly, body streaming and disconnects for one beat against its context.
module lpd_frame_logic (
  input  lpd_pkg::item_t   item,
  input  lpd_pkg::ctx_t    ctx,
  output logic             in_range,
  output lpd_pkg::ctx_t    ctx_nxt,
  output lpd_pkg::result_t res
);

  logic [lpd_pkg::LEN_W-1:0] built_len;
  logic [lpd_pkg::LEN_W-1:0] remaining;

  assign in_range  = (32'(item.connection_id) < 32'(lpd_pkg::CONNECTIONS));
  assign built_len = ctx.length_or_remaining
                   | (lpd_pkg::LEN_W'(item.data_byte) << {ctx.header_count, 3'b000});
  assign remaining = ctx.length_or_remaining - lpd_pkg::LEN_W'(1);

  always_comb begin
    ctx_nxt            = ctx;
    res.valid          = 1'b0;
    res.out_connection = item.connection_id;
    res.payload_byte   = item.data_byte;
    res.first_byte     = 1'b0;
    res.last_byte      = 1'b0;
    res.empty_message  = 1'b0;

    if (item.opcode == lpd_pkg::OP_DISCONNECT) begin
      ctx_nxt = lpd_pkg::CTX_IDLE;
    end else if (ctx.phase == lpd_pkg::PH_HEADER) begin
      ctx_nxt.length_or_remaining = built_len;
      if (ctx.header_count != lpd_pkg::HDR_LAST) begin
        ctx_nxt.header_count = ctx.header_count + lpd_pkg::CNT_W'(1);
      end else begin
        ctx_nxt.header_count = '0;
        ctx_nxt.body_started = 1'b0;
        if (built_len == '0) begin
          res.valid         = 1'b1;
          res.payload_byte  = '0;
          res.last_byte     = 1'b1;
          res.empty_message = 1'b1;
        end else begin
          ctx_nxt.phase = lpd_pkg::PH_BODY;
        end
      end
    end else begin
      ctx_nxt.length_or_remaining = remaining;
      ctx_nxt.body_started        = 1'b1;
      res.valid                   = 1'b1;
      res.first_byte              = ~ctx.body_started;
      res.last_byte               = (remaining == '0);
      if (remaining == '0) begin
        ctx_nxt.phase        = lpd_pkg::PH_HEADER;
        ctx_nxt.body_started = 1'b0;
        ctx_nxt.header_count = '0;
      end
    end

    if (!in_range) begin
      res.valid = 1'b0;
    end
  end

endmodule

// ----- rtl/length_prefix_deframer.sv -----
// Top level of the per-connection length-prefix deframer.
// Each accepted beat is registered in in_r, and its result beat is offered from out_r.
// Throughput: one input beat per cycle unless the output stalls; the processing stage
// reads and writes the connection's context in the same cycle; beats never wait on it.
// Reset: synchronous, active low; clears both valid flags and all connection contexts
// at once, with no clearing pass.
module length_prefix_deframer (
  input  logic      clk,
  input  logic      rst_n,
  lpd_in_if.sink    in_ch,
  lpd_out_if.source out_ch
);

  lpd_pkg::item_t   in_r;
  logic             in_valid_r;
  lpd_pkg::result_t out_r;
  logic             out_valid_r;

  lpd_pkg::ctx_t    rd_ctx;
  lpd_pkg::ctx_t    ctx_nxt;
  lpd_pkg::result_t res;
  logic             in_range;
  logic             advance;
  logic             in_take;

  assign advance     = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = rst_n & (~in_valid_r | advance);
  assign in_take     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.opcode        <= in_ch.opcode;
      in_r.connection_id <= in_ch.connection_id;
      in_r.data_byte     <= in_ch.data_byte;
    end
  end

  lpd_ctx_table u_ctx_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (in_r.connection_id[lpd_pkg::IDX_W-1:0]),
    .rd_ctx (rd_ctx),
    .wr_en  (advance & in_valid_r & in_range),
    .wr_idx (in_r.connection_id[lpd_pkg::IDX_W-1:0]),
    .wr_ctx (ctx_nxt)
  );

  lpd_frame_logic u_frame_logic (
    .item     (in_r),
    .ctx      (rd_ctx),
    .in_range (in_range),
    .ctx_nxt  (ctx_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r & res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_connection = out_r.out_connection;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.first_byte     = out_r.first_byte;
  assign out_ch.last_byte      = out_r.last_byte;
  assign out_ch.empty_message  = out_r.empty_message;

endmodule

// ----- rtl/lpd_checker.sv -----
// Port-level checker for the deframer and the bind that attaches it.
module lpd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lpd_pkg::ID_W-1:0]   out_connection,
  input logic [lpd_pkg::BYTE_W-1:0] payload_byte,
  input logic                       first_byte,
  input logic                       last_byte,
  input logic                       empty_message
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat offered right after reset.");

  a_ready_when_out_free: assert property (@(posedge clk)
    (rst_n && !out_valid) |-> in_ready)
    else $error("Input stalled while the result register is free.");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("Result beat appeared without an input beat two cycles earlier.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_connection)
      && $stable(payload_byte) && $stable(first_byte) && $stable(last_byte)
      && $stable(empty_message)))
    else $error("Stalled result beat changed.");

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_connection (out_ch.out_connection),
  .payload_byte   (out_ch.payload_byte),
  .first_byte     (out_ch.first_byte),
  .last_byte      (out_ch.last_byte),
  .empty_message  (out_ch.empty_message)
);
